>>> rtl/mf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 median filter.
// No dependencies; take in first.
package mf_pkg;

   localparam int CFG_BITS      = 11;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CFG_BITS-1:0] RESET_FRAME_WIDTH  = 11'd256;
   localparam logic [CFG_BITS-1:0] RESET_FRAME_HEIGHT = 11'd256;

   // register index is address bit 2
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } cfg_reg_type;

   // which parts of the 3x3 window fall outside the frame
   typedef struct packed {
      logic top_zero;
      logic bot_zero;
      logic left_zero;
      logic right_zero;
   } border_mask_type;

endpackage

>>> rtl/mf_req_if.sv
`timescale 1ns / 1ps
// Request channel: one pixel or flush marker per transfer.
// Standalone; no package needed.
interface mf_req_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel;
   logic                         flush;

   modport source (output valid, pixel, flush, input ready);
   modport sink   (input valid, pixel, flush, output ready);
endinterface

>>> rtl/mf_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: one median per transfer with end-of-frame flag.
// Standalone; no package needed.
interface mf_rsp_if #(parameter int PIXEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] median;
   logic                         last_of_frame;

   modport source (output valid, median, last_of_frame, input ready);
   modport sink   (input valid, median, last_of_frame, output ready);
endinterface

>>> rtl/median_filter_3x3.sv
`timescale 1ns / 1ps
// 3x3 median filter over a raster pixel stream, zero outside the frame.
// One request per clock unless responses stall; the line store has one write and one read port.
// A result is registered in the request stage and in each mf_median9 stage before it leaves.
// Reset (synchronous): frame 256x256, counters and pipeline valids clear; line store and
// window are not cleared, as stale entries are always masked as outside the frame.
// Depends on mf_pkg, mf_req_if, mf_rsp_if, mf_column_cell, mf_median9.
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   mf_req_if.sink                              req_if,
   mf_rsp_if.source                            rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mf_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [mf_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [mf_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import mf_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int XW0 = (CFG_BITS > RW) ? CFG_BITS : RW;
   localparam int XW1 = (XW0 > $clog2(MAX_WIDTH + 1)) ? XW0 : $clog2(MAX_WIDTH + 1);
   localparam int XW  = XW1 + 1;
   localparam int PB  = PIXEL_BITS;

   typedef logic signed [PB-1:0] pix_type;

   // ---------------- configuration registers ----------------
   logic [CFG_BITS-1:0] width_ff, height_ff;
   logic                csr_write;
   cfg_reg_type         csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = cfg_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_FRAME_WIDTH;
         height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_write) begin
         case (csr_reg)
            REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[CFG_BITS-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamp to the supported frame: zero acts as one, oversize as the maximum
   logic [XW-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0)                         w_eff = XW'(1);
      else if (XW'(width_ff) > XW'(MAX_WIDTH))    w_eff = XW'(MAX_WIDTH);
      else                                        w_eff = XW'(width_ff);
      if (height_ff == '0)                        h_eff = XW'(1);
      else if (XW'(height_ff) > XW'(MAX_HEIGHT))  h_eff = XW'(MAX_HEIGHT);
      else                                        h_eff = XW'(height_ff);
   end

   // ---------------- raster counters and request decode ----------------
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [XW-1:0]   col_x, row_x, col_next;
   logic            accept, keep, drop, zero_pix, emit, col_zero, last;
   border_mask_type mask;
   pix_type         pix_v;
   logic            s1_valid_ff, s1_adv, s1_write;

   assign col_x    = XW'(col_ff);
   assign row_x    = XW'(row_ff);
   assign col_next = col_x + XW'(1);

   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_if.valid && req_if.ready;
   // a flush at the frame start is a no-op
   assign drop         = req_if.flush && (row_ff == '0) && (col_ff == '0);
   assign keep         = accept && !drop;

   assign zero_pix = req_if.flush || (row_x >= h_eff);
   assign pix_v    = zero_pix ? '0 : req_if.pixel;
   assign emit     = (row_x >= XW'(2)) || ((row_x == XW'(1)) && (col_x >= XW'(1)));
   assign col_zero = (col_ff == '0);

   // at column zero the window still holds the previous row's last pixel
   always_comb begin
      if (col_zero) begin
         mask.top_zero  = (row_x == XW'(2));
         mask.bot_zero  = (row_x >= h_eff + XW'(1));
         mask.left_zero = (w_eff == XW'(1));
      end else begin
         mask.top_zero  = (row_x == XW'(1));
         mask.bot_zero  = (row_x >= h_eff);
         mask.left_zero = (col_x == XW'(1));
      end
      mask.right_zero = col_zero;
   end

   assign last = emit && col_zero && (row_x == h_eff + XW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (keep) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= w_eff) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line store: {upper, lower} per column ----------------
   logic [2*PB-1:0] line_mem [MAX_WIDTH];
   logic [2*PB-1:0] rd_ff, fwd_data_ff, rd_eff, wr_data;
   logic [CW-1:0]   s1_idx_ff;
   logic            s1_fwd_ff, s1_emit_ff, s1_last_ff;
   pix_type         s1_pix_ff;
   border_mask_type s1_mask_ff;
   logic            med_in_ready;

   assign s1_adv   = s1_valid_ff && (!s1_emit_ff || med_in_ready);
   assign s1_write = s1_adv;
   // a read of the entry written in the same cycle, as in a one-column frame, takes the forwarded data
   assign rd_eff   = s1_fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data  = {rd_eff[PB-1:0], s1_pix_ff};

   always_ff @(posedge clock) begin
      if (s1_write) begin
         line_mem[s1_idx_ff] <= wr_data;
      end
      if (keep) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (keep) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         s1_idx_ff   <= col_ff;
         s1_pix_ff   <= pix_v;
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_mask_ff  <= mask;
         s1_fwd_ff   <= s1_valid_ff && (s1_idx_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   // ---------------- window: chain of column cells ----------------
   pix_type new_col [3];
   pix_type right_col [3];
   pix_type mid_col [3];
   pix_type win [9];

   assign new_col[0] = rd_eff[2*PB-1:PB];
   assign new_col[1] = rd_eff[PB-1:0];
   assign new_col[2] = s1_pix_ff;

   mf_column_cell #(.PIXEL_BITS(PB)) u_cell_right (
      .clock   (clock),
      .shift   (s1_write),
      .col_in  (new_col),
      .col_out (right_col)
   );

   mf_column_cell #(.PIXEL_BITS(PB)) u_cell_mid (
      .clock   (clock),
      .shift   (s1_write),
      .col_in  (right_col),
      .col_out (mid_col)
   );

   // drop rows and columns that lie outside the frame
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic row_off;
         row_off = ((k == 0) && s1_mask_ff.top_zero) || ((k == 2) && s1_mask_ff.bot_zero);
         win[3*k]   = (row_off || s1_mask_ff.left_zero)  ? '0 : mid_col[k];
         win[3*k+1] =  row_off                           ? '0 : right_col[k];
         win[3*k+2] = (row_off || s1_mask_ff.right_zero) ? '0 : new_col[k];
      end
   end

   // ---------------- median pipeline and response register ----------------
   mf_median9 #(.PIXEL_BITS(PB)) u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff && s1_emit_ff),
      .in_last   (s1_last_ff),
      .in_win    (win),
      .in_ready  (med_in_ready),
      .out_valid (rsp_if.valid),
      .out_last  (rsp_if.last_of_frame),
      .out_med   (rsp_if.median),
      .out_ready (rsp_if.ready)
   );

endmodule

>>> rtl/mf_column_cell.sv
`timescale 1ns / 1ps
// One window column cell: holds three rows of one column, shifts on demand.
// Chained cell to cell in the top level; no package needed.
module mf_column_cell #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic signed [PIXEL_BITS-1:0] col_in  [3],
   output logic signed [PIXEL_BITS-1:0] col_out [3]
);

   logic signed [PIXEL_BITS-1:0] col_ff [3];

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

>>> rtl/mf_median9.sv
`timescale 1ns / 1ps
// Three-stage exact median of nine: sort rows, reduce columns, median of three.
// Valid/ready between stages; no package needed.
module mf_median9 #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_last,
   input  logic signed [PIXEL_BITS-1:0] in_win [9],
   output logic                         in_ready,
   output logic                         out_valid,
   output logic                         out_last,
   output logic signed [PIXEL_BITS-1:0] out_med,
   input  logic                         out_ready
);

   typedef logic signed [PIXEL_BITS-1:0] pix_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   pix_type lo_ff [3], mi_ff [3], hi_ff [3];
   pix_type lo_in [3], mi_in [3], hi_in [3];
   pix_type red_ff [3], red_in [3];
   pix_type med_ff;
   logic    b_valid_ff, b_last_ff, c_valid_ff, c_last_ff, d_valid_ff, d_last_ff;
   logic    b_free, c_free, d_free;

   assign d_free   = !d_valid_ff || out_ready;
   assign c_free   = !c_valid_ff || d_free;
   assign b_free   = !b_valid_ff || c_free;
   assign in_ready = b_free;

   // sort each row of three
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         lo_in[g] = min2(min2(in_win[3*g], in_win[3*g+1]), in_win[3*g+2]);
         hi_in[g] = max2(max2(in_win[3*g], in_win[3*g+1]), in_win[3*g+2]);
         mi_in[g] = med3(in_win[3*g], in_win[3*g+1], in_win[3*g+2]);
      end
   end

   // largest low, middle middle, smallest high
   always_comb begin
      red_in[0] = max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
      red_in[1] = med3(mi_ff[0], mi_ff[1], mi_ff[2]);
      red_in[2] = min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (b_free) b_valid_ff <= in_valid;
         if (c_free) c_valid_ff <= b_valid_ff;
         if (d_free) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free) begin
         lo_ff     <= lo_in;
         mi_ff     <= mi_in;
         hi_ff     <= hi_in;
         b_last_ff <= in_last;
      end
      if (c_free) begin
         red_ff    <= red_in;
         c_last_ff <= b_last_ff;
      end
      if (d_free) begin
         med_ff    <= med3(red_ff[0], red_ff[1], red_ff[2]);
         d_last_ff <= c_last_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_last  = d_last_ff;
   assign out_med   = med_ff;

endmodule

>>> rtl/mf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the median filter, bound to the top level.
// Depends on median_filter_3x3 and its interface ports.
module mf_checker #(
   parameter int PIXEL_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIXEL_BITS-1:0] rsp_median,
   input logic                  rsp_last,
   input logic                  csr_pready
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // empty pipeline takes a request at once
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median) && $stable(rsp_last))
      else $error("stalled response changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind median_filter_3x3 mf_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_median (rsp_if.median),
   .rsp_last   (rsp_if.last_of_frame),
   .csr_pready (csr_pready)
);
